// File: sv/hpq_pkg.sv
// hpq_pkg: shared types, codes and the ordering function of the heap priority queue
// used by hpq_ctrl and binary_heap_priority_queue; depends on nothing

package hpq_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 7;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [COUNT_W-1:0]        count_t;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e   cmd;
    value_t value;
  } in_t;

  typedef struct packed {
    value_t  top_value;
    logic    is_empty;
    count_t  count;
    status_e status;
  } out_t;

  // true when a must sit below b in the heap
  function automatic logic ranks_below(value_t a, value_t b, logic min_first);
    ranks_below = min_first ? (a > b) : (a < b);
  endfunction

endpackage

// File: sv/hpq_mem.sv
// hpq_mem: heap entry store, one write port and two registered read ports
// stand-alone, no package needed

module hpq_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

// File: sv/hpq_ctrl.sv
// hpq_ctrl: push/pop sequencer, sifts a hole through the heap held in hpq_mem
// depends on hpq_pkg

module hpq_ctrl #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH),
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   min_first_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  hpq_pkg::in_t           in_data_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output hpq_pkg::out_t          res_o,
  output logic                   mem_we_o,
  output logic [AW-1:0]          mem_waddr_o,
  output hpq_pkg::value_t        mem_wdata_o,
  output logic                   mem_re_o,
  output logic [AW-1:0]          mem_raddr_a_o,
  output logic [AW-1:0]          mem_raddr_b_o,
  input  hpq_pkg::value_t        mem_rdata_a_i,
  input  hpq_pkg::value_t        mem_rdata_b_i
);

  localparam int unsigned LW = AW + 1;

  typedef enum logic [6:0] {
    IDLE     = 7'b0000001,
    UP_RD    = 7'b0000010,
    UP_CMP   = 7'b0000100,
    LOAD     = 7'b0001000,
    DOWN_RD  = 7'b0010000,
    DOWN_CMP = 7'b0100000,
    DONE     = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [AW-1:0]    pos_q, pos_d;
  hpq_pkg::value_t  val_q, val_d;
  hpq_pkg::value_t  top_q, top_d;
  hpq_pkg::status_e status_q, status_d;

  logic             accept;
  logic [LW-1:0]    left;
  logic [LW-1:0]    right;
  logic [AW-1:0]    parent;
  logic             has_left;
  logic             has_right;
  logic             pick_right;
  hpq_pkg::value_t  child_val;
  logic [AW-1:0]    child_pos;

  assign in_ready_o = (state_q == IDLE);
  assign accept     = in_valid_i & in_ready_o;

  assign left       = (LW'(pos_q) << 1) + LW'(1);
  assign right      = left + LW'(1);
  assign has_left   = left < LW'(cnt_q);
  assign has_right  = right < LW'(cnt_q);
  assign parent     = (pos_q - AW'(1)) >> 1;
  assign pick_right = has_right & hpq_pkg::ranks_below(mem_rdata_a_i, mem_rdata_b_i, min_first_i);
  assign child_val  = pick_right ? mem_rdata_b_i : mem_rdata_a_i;
  assign child_pos  = pick_right ? AW'(right) : AW'(left);

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    pos_d         = pos_q;
    val_d         = val_q;
    status_d      = status_q;
    mem_we_o      = 1'b0;
    mem_waddr_o   = pos_q;
    mem_wdata_o   = val_q;
    mem_re_o      = 1'b0;
    mem_raddr_a_o = AW'(left);
    mem_raddr_b_o = AW'(right);
    case (state_q)
      IDLE: begin
        if (accept) begin
          status_d = hpq_pkg::ST_OK;
          if (in_data_i.cmd == hpq_pkg::CMD_PUSH) begin
            if (cnt_q == CW'(DEPTH)) begin
              status_d = hpq_pkg::ST_FULL;
              state_d  = DONE;
            end else begin
              val_d   = in_data_i.value;
              pos_d   = AW'(cnt_q);
              cnt_d   = cnt_q + CW'(1);
              state_d = UP_RD;
            end
          end else begin
            if (cnt_q == '0) begin
              status_d = hpq_pkg::ST_EMPTY;
              state_d  = DONE;
            end else begin
              cnt_d = cnt_q - CW'(1);
              pos_d = '0;
              if (cnt_q == CW'(1)) begin
                state_d = DONE;
              end else begin
                mem_re_o      = 1'b1;
                mem_raddr_a_o = AW'(cnt_q - CW'(1));
                state_d       = LOAD;
              end
            end
          end
        end
      end
      UP_RD: begin
        if (pos_q == '0) begin
          mem_we_o = 1'b1;
          state_d  = DONE;
        end else begin
          mem_re_o      = 1'b1;
          mem_raddr_a_o = parent;
          state_d       = UP_CMP;
        end
      end
      UP_CMP: begin
        mem_we_o = 1'b1;
        if (hpq_pkg::ranks_below(mem_rdata_a_i, val_q, min_first_i)) begin
          mem_wdata_o = mem_rdata_a_i;
          pos_d       = parent;
          state_d     = UP_RD;
        end else begin
          state_d = DONE;
        end
      end
      LOAD: begin
        val_d   = mem_rdata_a_i;
        state_d = DOWN_RD;
      end
      DOWN_RD: begin
        if (has_left) begin
          mem_re_o = 1'b1;
          state_d  = DOWN_CMP;
        end else begin
          mem_we_o = 1'b1;
          state_d  = DONE;
        end
      end
      DOWN_CMP: begin
        mem_we_o = 1'b1;
        if (hpq_pkg::ranks_below(val_q, child_val, min_first_i)) begin
          mem_wdata_o = child_val;
          pos_d       = child_pos;
          state_d     = DOWN_RD;
        end else begin
          state_d = DONE;
        end
      end
      DONE: begin
        if (res_ready_i) begin
          state_d = IDLE;
        end
      end
      default: begin
        state_d = IDLE;
      end
    endcase
  end

  always_comb begin
    top_d = top_q;
    if (mem_we_o && (mem_waddr_o == '0)) begin
      top_d = mem_wdata_o;
    end
  end

  assign res_valid_o        = (state_q == DONE);
  assign res_o.top_value    = (cnt_q == '0) ? '0 : top_q;
  assign res_o.is_empty     = (cnt_q == '0);
  assign res_o.count        = hpq_pkg::count_t'(cnt_q);
  assign res_o.status       = status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= IDLE;
      cnt_q    <= '0;
      status_q <= hpq_pkg::ST_OK;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    val_q <= val_d;
    top_q <= top_d;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we_o && mem_re_o))
    else $error("read and write issued in the same cycle");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == IDLE || state_q == DONE) |-> !mem_we_o)
    else $error("store written outside a sift");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.cmd == hpq_pkg::CMD_POP && cnt_q != '0)
      |=> cnt_q == $past(cnt_q) - CW'(1))
    else $error("pop did not remove one entry");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.cmd == hpq_pkg::CMD_PUSH && cnt_q != CW'(DEPTH))
      |=> cnt_q == $past(cnt_q) + CW'(1))
    else $error("push did not add one entry");

endmodule

// File: sv/binary_heap_priority_queue.sv
// binary_heap_priority_queue: top level, config register, result register
// depends on hpq_pkg, hpq_ctrl, hpq_mem
//
//  channel  signals                            payload
//  cfg      cfg_we_i                           cfg_wdata_i (min_first)
//  in       in_valid_i / in_ready_o            in_data_i  (hpq_pkg::in_t)
//  out      out_valid_o / out_ready_i          out_data_o (hpq_pkg::out_t)
//
// one item at a time; a push sifts a hole up from the new leaf, a pop loads
// the last entry and sifts it down from the root; each level moved is a read
// of the store, then a compare and write; at the root or a leaf the sift ends
// with a write alone; full push, empty pop and pop of the last entry need no sift
// reset clears count and control; store contents need no clearing
// a taken result frees the sequencer while the result register waits on out_ready_i

module binary_heap_priority_queue #(
  parameter int unsigned DEPTH = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  hpq_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output hpq_pkg::out_t  out_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic            min_first_q, min_first_d;
  logic            out_valid_q, out_valid_d;
  hpq_pkg::out_t   out_data_q;

  logic            res_valid;
  logic            res_ready;
  hpq_pkg::out_t   res;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  hpq_pkg::value_t mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr_a;
  logic [AW-1:0]   mem_raddr_b;
  hpq_pkg::value_t mem_rdata_a;
  hpq_pkg::value_t mem_rdata_b;

  hpq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .min_first_i   (min_first_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_raddr_a_o (mem_raddr_a),
    .mem_raddr_b_o (mem_raddr_b),
    .mem_rdata_a_i (mem_rdata_a),
    .mem_rdata_b_i (mem_rdata_b)
  );

  hpq_mem #(
    .DEPTH(DEPTH),
    .WIDTH(hpq_pkg::VALUE_W)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .re_i      (mem_re),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

  assign res_ready   = !out_valid_q || out_ready_i;
  assign min_first_d = cfg_we_i ? cfg_wdata_i : min_first_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_first_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      min_first_q <= min_first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
